// File: design/dlt_pkg.sv
// ---------------------------------------------------------------------------
// dlt_pkg: shared types and constants of the DHCP lease timer
// Request, result and record layouts, request and state codes, register
// indexes and reset values.
// ---------------------------------------------------------------------------
package dlt_pkg;

  // Request codes
  localparam logic [2:0] REQ_CLEAR   = 3'd0;
  localparam logic [2:0] REQ_BEGIN   = 3'd1;
  localparam logic [2:0] REQ_LEASE   = 3'd2;
  localparam logic [2:0] REQ_ATTEMPT = 3'd3;
  localparam logic [2:0] REQ_FAILURE = 3'd4;
  localparam logic [2:0] REQ_MANUAL  = 3'd5;

  // Address modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_DHCP   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  // Lease states
  localparam logic [2:0] LST_NONE      = 3'd0;
  localparam logic [2:0] LST_ACQUIRING = 3'd1;
  localparam logic [2:0] LST_BOUND     = 3'd2;
  localparam logic [2:0] LST_RENEWING  = 3'd3;
  localparam logic [2:0] LST_REBINDING = 3'd4;

  // Configuration registers
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INITIAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_CAP     = 1'd1;
  localparam logic [15:0] RETRY_INITIAL_RST = 16'd1000;
  localparam logic [15:0] RETRY_CAP_RST     = 16'd4000;

  localparam logic [31:0] MIN_LEASE_SECS = 32'd3;
  localparam logic [7:0]  MAX_PREFIX     = 8'd32;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] now_ms;
    logic [31:0] host_address;
    logic [31:0] offered_netmask;
    logic [7:0]  manual_prefix;
    logic [31:0] gateway_address;
    logic [31:0] dns_address;
    logic [31:0] lease_secs;
    logic [31:0] renew_secs;
    logic [31:0] rebind_secs;
    logic        is_rebinding;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  mode_now;
    logic [2:0]  lease_state;
    logic        is_configured;
    logic [31:0] netmask_out;
    logic [5:0]  prefix_out;
    logic [63:0] renew_deadline;
    logic [63:0] rebind_deadline;
    logic [63:0] expiry_deadline;
    logic [63:0] retry_deadline;
    logic [15:0] retry_delay;
  } res_t;

  // Checked and normalized lease terms plus the manual setting
  typedef struct packed {
    logic        lease_ok;
    logic [31:0] t1_secs;
    logic [31:0] t2_secs;
    logic [5:0]  mask_prefix;
    logic        manual_ok;
    logic [31:0] manual_mask;
    logic [5:0]  manual_prefix;
  } norm_t;

  // Lease durations in milliseconds
  typedef struct packed {
    logic [63:0] lease_ms;
    logic [63:0] t1_ms;
    logic [63:0] t2_ms;
  } dur_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  lease_state;
    logic        configured;
    logic [31:0] netmask;
    logic [5:0]  prefix;
    logic [63:0] renew_dl;
    logic [63:0] rebind_dl;
    logic [63:0] expiry_dl;
    logic [63:0] retry_dl;
    logic [15:0] retry_delay;
  } rec_t;

endpackage

// File: design/dlt_req_if.sv
// ---------------------------------------------------------------------------
// dlt_req_if: request channel
// Valid/ready channel carrying one lease request per transaction.
// ---------------------------------------------------------------------------
interface dlt_req_if;
  logic          valid;
  logic          ready;
  dlt_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/dlt_res_if.sv
// ---------------------------------------------------------------------------
// dlt_res_if: result channel
// Valid/ready channel carrying the acceptance flag and record snapshot.
// ---------------------------------------------------------------------------
interface dlt_res_if;
  logic          valid;
  logic          ready;
  dlt_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/dlt_cfg_if.sv
// ---------------------------------------------------------------------------
// dlt_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface dlt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dlt_pkg::CFG_IDX_W-1:0]     index;
  logic [15:0]                       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/dlt_lease_norm.sv
// ---------------------------------------------------------------------------
// dlt_lease_norm: lease and manual request checks
// Validates address and netmask, normalizes T1/T2 against the lease and
// prepares the manual netmask.
// ---------------------------------------------------------------------------
module dlt_lease_norm (
  input  dlt_pkg::req_t  req_i,
  output dlt_pkg::norm_t norm_o
);

  logic [31:0] inv_mask;
  logic        mask_ok;
  logic [31:0] lease;
  logic [34:0] lease_x7;
  logic [31:0] t1_a, t2_a, t1_b, t2_b, t2_c;
  logic        addr_ok;

  assign lease    = req_i.lease_secs;
  assign inv_mask = ~req_i.offered_netmask;
  // Contiguous ones from the top: the inverted mask is of the form 0..01..1
  assign mask_ok  = ((inv_mask & (inv_mask + 32'd1)) == 32'd0);
  assign addr_ok  = (req_i.host_address != 32'd0);
  assign lease_x7 = {lease, 3'b000} - {3'b000, lease};

  always_comb begin
    t1_a = (req_i.renew_secs == 32'd0) ? (lease >> 1) : req_i.renew_secs;
    t2_a = (req_i.rebind_secs == 32'd0) ? lease_x7[34:3] : req_i.rebind_secs;
    t1_b = (t1_a == 32'd0) ? 32'd1 : t1_a;
    t2_b = (t2_a <= t1_b) ? (t1_b + 32'd1) : t2_a;
    t2_c = (t2_b >= lease) ? (lease - 32'd1) : t2_b;
  end

  always_comb begin
    norm_o.lease_ok    = addr_ok && mask_ok && (lease >= dlt_pkg::MIN_LEASE_SECS) &&
                         (t1_b < t2_c) && (t2_c < lease);
    norm_o.t1_secs     = t1_b;
    norm_o.t2_secs     = t2_c;
    norm_o.mask_prefix = 6'($countones(req_i.offered_netmask));
    norm_o.manual_ok   = (req_i.manual_prefix <= dlt_pkg::MAX_PREFIX) && addr_ok &&
                         (req_i.gateway_address != 32'd0) &&
                         (req_i.dns_address != 32'd0);
    norm_o.manual_mask   = ~(32'hFFFF_FFFF >> req_i.manual_prefix[5:0]);
    norm_o.manual_prefix = req_i.manual_prefix[5:0];
  end

endmodule

// File: design/dhcp_lease_timer_unit.sv
// ---------------------------------------------------------------------------
// dhcp_lease_timer_unit: IPv4 lease record with T1/T2/expiry/retry timers
// Applies clear, acquire, lease, attempt, failure and manual requests to
// the record and returns the acceptance flag with a record snapshot.
// ---------------------------------------------------------------------------
//
//   channel | dir | handshake    | carries
//   --------+-----+--------------+-----------------------------------------
//   req_i   | in  | valid/ready  | one lease request per transaction
//   res_o   | out | valid/ready  | accepted flag and record snapshot
//   cfg_i   | in  | valid/ready  | retry register index and write data
//
// One request per cycle sustained while res_o takes its results. A request
// taken into the input register feeds normalize/check, the scaling to
// milliseconds, the deadline adders and the record update, which load the
// result register in one pass.
// The record changes only as a request loads the result register, so the
// next request always sees the record its predecessor left.
// Back-pressure on res_o holds the result register, then the input register.
// Reset clears the record and loads the retry registers; no clearing pass.
//
module dhcp_lease_timer_unit #(
  parameter int unsigned MS_PER_SECOND = 1000
) (
  input  logic clk_i,
  input  logic rst_ni,
  dlt_req_if.sink   req_i,
  dlt_res_if.source res_o,
  dlt_cfg_if.sink   cfg_i
);

  localparam int unsigned MsW  = $clog2(MS_PER_SECOND + 1);
  localparam int unsigned MulW = 32 + MsW;

  // ------------------------------------------------------------------
  // Retry registers
  // ------------------------------------------------------------------
  logic [15:0] retry_init_q, retry_cap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_init_q <= dlt_pkg::RETRY_INITIAL_RST;
      retry_cap_q  <= dlt_pkg::RETRY_CAP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dlt_pkg::CFG_RETRY_INITIAL: retry_init_q <= cfg_i.data;
        dlt_pkg::CFG_RETRY_CAP:     retry_cap_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Flow control: a register may load when it is empty or moving on
  // ------------------------------------------------------------------
  logic s1_vld_q, out_vld_q;
  logic out_free, s1_free;

  assign out_free    = !out_vld_q || res_o.ready;
  assign s1_free     = !s1_vld_q || out_free;
  assign req_i.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free)  s1_vld_q  <= req_i.valid;
      if (out_free) out_vld_q <= s1_vld_q;
    end
  end

  // ------------------------------------------------------------------
  // Input register: capture the request
  // ------------------------------------------------------------------
  dlt_pkg::req_t s1_req_q;

  always_ff @(posedge clk_i) begin
    if (req_i.valid && s1_free) s1_req_q <= req_i.payload;
  end

  // ------------------------------------------------------------------
  // Lease checks, T1/T2 normalization, manual netmask
  // ------------------------------------------------------------------
  dlt_pkg::norm_t norm;

  dlt_lease_norm u_norm (
    .req_i  (s1_req_q),
    .norm_o (norm)
  );

  // ------------------------------------------------------------------
  // Scale lease, T1 and T2 to milliseconds (constant multiplies)
  // ------------------------------------------------------------------
  dlt_pkg::dur_t dur;

  always_comb begin
    dur.lease_ms = 64'(MulW'(s1_req_q.lease_secs) * MulW'(MS_PER_SECOND));
    dur.t1_ms    = 64'(MulW'(norm.t1_secs) * MulW'(MS_PER_SECOND));
    dur.t2_ms    = 64'(MulW'(norm.t2_secs) * MulW'(MS_PER_SECOND));
  end

  // ------------------------------------------------------------------
  // Deadline adders and record update
  // ------------------------------------------------------------------
  dlt_pkg::rec_t rec_q, rec_d;
  logic          acc;
  logic [64:0]   exp_sum, t1_sum, t2_sum, retry_sum;
  logic [63:0]   retry_sat;
  logic [2:0]    attempt_state;
  logic [15:0]   delay_new;
  logic [16:0]   delay_dbl;
  logic          dhcp_live;

  assign exp_sum = {1'b0, s1_req_q.now_ms} + {1'b0, dur.lease_ms};
  assign t1_sum  = {1'b0, s1_req_q.now_ms} + {1'b0, dur.t1_ms};
  assign t2_sum  = {1'b0, s1_req_q.now_ms} + {1'b0, dur.t2_ms};

  assign dhcp_live     = (rec_q.mode == dlt_pkg::MODE_DHCP) && rec_q.configured;
  assign attempt_state = s1_req_q.is_rebinding ? dlt_pkg::LST_REBINDING
                                               : dlt_pkg::LST_RENEWING;
  assign delay_dbl     = {rec_q.retry_delay, 1'b0};

  // Pick the delay the attempt or failure leaves behind
  always_comb begin
    delay_new = rec_q.retry_delay;
    if (s1_req_q.req_type == dlt_pkg::REQ_ATTEMPT) begin
      // restart the delay on a new phase or when it has run down to zero
      if (rec_q.lease_state != attempt_state || rec_q.retry_delay == 16'd0) begin
        delay_new = retry_init_q;
      end
    end else if (rec_q.retry_delay < retry_cap_q) begin
      delay_new = (delay_dbl > {1'b0, retry_cap_q}) ? retry_cap_q : delay_dbl[15:0];
    end
  end

  // Saturate now plus delay at all ones
  assign retry_sum = {1'b0, s1_req_q.now_ms} + 65'(delay_new);
  assign retry_sat = retry_sum[64] ? '1 : retry_sum[63:0];

  always_comb begin
    rec_d = rec_q;
    acc   = 1'b0;
    unique case (s1_req_q.req_type)
      dlt_pkg::REQ_CLEAR: begin
        rec_d = '0;
        acc   = 1'b1;
      end
      dlt_pkg::REQ_BEGIN: begin
        rec_d             = '0;
        rec_d.mode        = dlt_pkg::MODE_DHCP;
        rec_d.lease_state = dlt_pkg::LST_ACQUIRING;
        acc               = 1'b1;
      end
      dlt_pkg::REQ_LEASE: begin
        // Write expiry, T1, T2 in turn; the first overflow stops the chain
        // and leaves the earlier deadlines in place.
        if (norm.lease_ok && !exp_sum[64]) begin
          rec_d.expiry_dl = exp_sum[63:0];
          if (!t1_sum[64]) begin
            rec_d.renew_dl = t1_sum[63:0];
            if (!t2_sum[64]) begin
              rec_d.rebind_dl   = t2_sum[63:0];
              rec_d.netmask     = s1_req_q.offered_netmask;
              rec_d.prefix      = norm.mask_prefix;
              rec_d.mode        = dlt_pkg::MODE_DHCP;
              rec_d.retry_dl    = t1_sum[63:0];
              rec_d.retry_delay = retry_init_q;
              rec_d.lease_state = dlt_pkg::LST_BOUND;
              rec_d.configured  = 1'b1;
              acc               = 1'b1;
            end
          end
        end
      end
      dlt_pkg::REQ_ATTEMPT: begin
        if (dhcp_live) begin
          rec_d.lease_state = attempt_state;
          rec_d.retry_delay = delay_new;
          rec_d.retry_dl    = retry_sat;
          acc               = 1'b1;
        end
      end
      dlt_pkg::REQ_FAILURE: begin
        if (dhcp_live && (rec_q.lease_state == dlt_pkg::LST_RENEWING ||
                          rec_q.lease_state == dlt_pkg::LST_REBINDING)) begin
          rec_d.retry_delay = delay_new;
          // clamp to T2 while renewing, to expiry while rebinding
          if (rec_q.lease_state == dlt_pkg::LST_RENEWING) begin
            rec_d.retry_dl = (retry_sat < rec_q.rebind_dl) ? retry_sat : rec_q.rebind_dl;
          end else begin
            rec_d.retry_dl = (retry_sat < rec_q.expiry_dl) ? retry_sat : rec_q.expiry_dl;
          end
          acc = 1'b1;
        end
      end
      dlt_pkg::REQ_MANUAL: begin
        if (norm.manual_ok) begin
          rec_d            = '0;
          rec_d.netmask    = norm.manual_mask;
          rec_d.prefix     = norm.manual_prefix;
          rec_d.mode       = dlt_pkg::MODE_MANUAL;
          rec_d.configured = 1'b1;
          acc              = 1'b1;
        end
      end
      default: ;  // unknown request: hold the record, reject
    endcase
  end

  // Advance the record only as the request leaves for the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (s1_vld_q && out_free) begin
      rec_q <= rec_d;
    end
  end

  // ------------------------------------------------------------------
  // Result register: snapshot of the record after the request
  // ------------------------------------------------------------------
  dlt_pkg::res_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && out_free) begin
      out_q.accepted        <= acc;
      out_q.mode_now        <= rec_d.mode;
      out_q.lease_state     <= rec_d.lease_state;
      out_q.is_configured   <= rec_d.configured;
      out_q.netmask_out     <= rec_d.netmask;
      out_q.prefix_out      <= rec_d.prefix;
      out_q.renew_deadline  <= rec_d.renew_dl;
      out_q.rebind_deadline <= rec_d.rebind_dl;
      out_q.expiry_deadline <= rec_d.expiry_dl;
      out_q.retry_deadline  <= rec_d.retry_dl;
      out_q.retry_delay     <= rec_d.retry_delay;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

endmodule

// File: design/dlt_checker.sv
// ---------------------------------------------------------------------------
// dlt_checker: port-level checks of the DHCP lease timer
// Record consistency seen on the result channel, plus result hold on stall.
// ---------------------------------------------------------------------------
module dlt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input dlt_pkg::res_t res_i
);

  // A stalled result holds its value
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i))
    else $error("result changed while stalled");

  // No mode means an empty, unconfigured record state
  a_mode_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.mode_now == dlt_pkg::MODE_NONE |->
      res_i.lease_state == dlt_pkg::LST_NONE && !res_i.is_configured)
    else $error("lease state or configured flag set without a mode");

  // Bound only in configured dhcp mode
  a_bound_dhcp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.lease_state == dlt_pkg::LST_BOUND |->
      res_i.mode_now == dlt_pkg::MODE_DHCP && res_i.is_configured)
    else $error("bound outside configured dhcp mode");

  // A freshly applied lease has ordered deadlines and retries at T1
  a_lease_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.accepted && res_i.lease_state == dlt_pkg::LST_BOUND |->
      res_i.renew_deadline < res_i.rebind_deadline &&
      res_i.rebind_deadline < res_i.expiry_deadline &&
      res_i.retry_deadline == res_i.renew_deadline)
    else $error("applied lease deadlines out of order");

  // Manual mode keeps no lease state and no retry delay
  a_manual_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.mode_now == dlt_pkg::MODE_MANUAL |->
      res_i.lease_state == dlt_pkg::LST_NONE && res_i.retry_delay == 16'd0)
    else $error("lease timing active in manual mode");

endmodule

bind dhcp_lease_timer_unit dlt_checker u_dlt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_i       (res_o.payload)
);

// File: bench/dlt_lease_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dlt_lease_checker: lease record predictor and result comparator
// Monitors the request, result and configuration channels of the DHCP lease
// timer. It mirrors the lease record for every request transaction and
// compares each result transaction, field by field, with the oldest snapshot
// still owed.
// ---------------------------------------------------------------------------
module dlt_lease_checker #(
  parameter int unsigned MS_PER_SECOND = 1000
) (
  input  logic clk_i,
  input  logic rst_ni,
  dlt_req_if   req_mon,
  dlt_res_if   res_mon,
  dlt_cfg_if   cfg_mon,
  output int   pending_o,
  output int   fail_count_o
);

  dlt_pkg::rec_t lease_rec;
  logic [15:0]   retry_init_ms;
  logic [15:0]   retry_cap_ms;
  dlt_pkg::res_t snapshot_q[$];

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    return (a > ~64'd0 - b) ? ~64'd0 : a + b;
  endfunction

  // Write now + secs in ms to dl unless the sum passes 2^64-1.
  function automatic logic stamp_deadline(input logic [63:0] now, input logic [31:0] secs,
                                          inout logic [63:0] dl);
    logic [63:0] span;
    span = 64'(secs) * 64'(MS_PER_SECOND);
    if (now > ~64'd0 - span) return 1'b0;
    dl = now + span;
    return 1'b1;
  endfunction

  // Apply one request to the mirrored record and return the snapshot owed.
  function automatic dlt_pkg::res_t advance_record(input dlt_pkg::req_t rq);
    dlt_pkg::res_t snap;
    logic          ok;
    logic [31:0]   inv;
    logic [31:0]   lease_s;
    logic [31:0]   t1;
    logic [31:0]   t2;
    logic [2:0]    target_state;
    logic [16:0]   doubled;
    logic [63:0]   retry;
    logic [63:0]   limit;
    ok = 1'b0;
    case (rq.req_type)
      dlt_pkg::REQ_CLEAR: begin
        lease_rec = '0;
        ok = 1'b1;
      end
      dlt_pkg::REQ_BEGIN: begin
        lease_rec = '0;
        lease_rec.mode = dlt_pkg::MODE_DHCP;
        lease_rec.lease_state = dlt_pkg::LST_ACQUIRING;
        ok = 1'b1;
      end
      dlt_pkg::REQ_LEASE: begin
        inv     = ~rq.offered_netmask;
        lease_s = rq.lease_secs;
        t1      = rq.renew_secs;
        t2      = rq.rebind_secs;
        if (t1 == 32'd0) t1 = lease_s >> 1;
        if (t2 == 32'd0) t2 = 32'((64'(lease_s) * 64'd7) >> 3);
        if (t1 == 32'd0) t1 = 32'd1;
        if (t2 <= t1) t2 = t1 + 32'd1;
        if (t2 >= lease_s) t2 = lease_s - 32'd1;
        ok = (rq.host_address != 32'd0) && ((inv & (inv + 32'd1)) == 32'd0) &&
             (lease_s >= dlt_pkg::MIN_LEASE_SECS) && (t1 != 32'd0) && (t1 < t2) &&
             (t2 < lease_s);
        // Deadlines land in order; the first overflow stops the rest.
        if (ok) ok = stamp_deadline(rq.now_ms, lease_s, lease_rec.expiry_dl);
        if (ok) ok = stamp_deadline(rq.now_ms, t1, lease_rec.renew_dl);
        if (ok) ok = stamp_deadline(rq.now_ms, t2, lease_rec.rebind_dl);
        if (ok) begin
          lease_rec.netmask     = rq.offered_netmask;
          lease_rec.prefix      = 6'($countones(rq.offered_netmask));
          lease_rec.mode        = dlt_pkg::MODE_DHCP;
          lease_rec.retry_dl    = lease_rec.renew_dl;
          lease_rec.retry_delay = retry_init_ms;
          lease_rec.lease_state = dlt_pkg::LST_BOUND;
          lease_rec.configured  = 1'b1;
        end
      end
      dlt_pkg::REQ_ATTEMPT: begin
        target_state = rq.is_rebinding ? dlt_pkg::LST_REBINDING : dlt_pkg::LST_RENEWING;
        if (lease_rec.mode == dlt_pkg::MODE_DHCP && lease_rec.configured) begin
          if (lease_rec.lease_state != target_state) begin
            lease_rec.lease_state = target_state;
            lease_rec.retry_delay = retry_init_ms;
          end else if (lease_rec.retry_delay == 16'd0) begin
            lease_rec.retry_delay = retry_init_ms;
          end
          lease_rec.retry_dl = add_sat(rq.now_ms, 64'(lease_rec.retry_delay));
          ok = 1'b1;
        end
      end
      dlt_pkg::REQ_FAILURE: begin
        if (lease_rec.mode == dlt_pkg::MODE_DHCP && lease_rec.configured &&
            (lease_rec.lease_state == dlt_pkg::LST_RENEWING ||
             lease_rec.lease_state == dlt_pkg::LST_REBINDING)) begin
          if (lease_rec.retry_delay < retry_cap_ms) begin
            doubled = {lease_rec.retry_delay, 1'b0};
            lease_rec.retry_delay = (doubled > {1'b0, retry_cap_ms}) ? retry_cap_ms
                                                                      : doubled[15:0];
          end
          limit = (lease_rec.lease_state == dlt_pkg::LST_RENEWING) ? lease_rec.rebind_dl
                                                                   : lease_rec.expiry_dl;
          retry = add_sat(rq.now_ms, 64'(lease_rec.retry_delay));
          lease_rec.retry_dl = (retry < limit) ? retry : limit;
          ok = 1'b1;
        end
      end
      dlt_pkg::REQ_MANUAL: begin
        if (rq.manual_prefix <= dlt_pkg::MAX_PREFIX && rq.host_address != 32'd0 &&
            rq.gateway_address != 32'd0 && rq.dns_address != 32'd0) begin
          lease_rec = '0;
          lease_rec.netmask = (rq.manual_prefix == 8'd0) ? 32'd0 :
                              32'hFFFF_FFFF << (8'd32 - rq.manual_prefix);
          lease_rec.prefix     = rq.manual_prefix[5:0];
          lease_rec.mode       = dlt_pkg::MODE_MANUAL;
          lease_rec.configured = 1'b1;
          ok = 1'b1;
        end
      end
      default: ok = 1'b0;
    endcase
    snap.accepted        = ok;
    snap.mode_now        = lease_rec.mode;
    snap.lease_state     = lease_rec.lease_state;
    snap.is_configured   = lease_rec.configured;
    snap.netmask_out     = lease_rec.netmask;
    snap.prefix_out      = lease_rec.prefix;
    snap.renew_deadline  = lease_rec.renew_dl;
    snap.rebind_deadline = lease_rec.rebind_dl;
    snap.expiry_deadline = lease_rec.expiry_dl;
    snap.retry_deadline  = lease_rec.retry_dl;
    snap.retry_delay     = lease_rec.retry_delay;
    return snap;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dlt_pkg::res_t want;
    dlt_pkg::res_t got;
    if (!rst_ni) begin
      lease_rec     = '0;
      retry_init_ms = dlt_pkg::RETRY_INITIAL_RST;
      retry_cap_ms  = dlt_pkg::RETRY_CAP_RST;
      snapshot_q.delete();
      pending_o     = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          dlt_pkg::CFG_RETRY_INITIAL: retry_init_ms = cfg_mon.data;
          dlt_pkg::CFG_RETRY_CAP:     retry_cap_ms  = cfg_mon.data;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        snapshot_q.push_back(advance_record(req_mon.payload));
      if (res_mon.valid && res_mon.ready) begin
        got = res_mon.payload;
        if (snapshot_q.size() == 0) begin
          $display("%0t ns: result with no request outstanding, actual %p", $time, got);
          fail_count_o++;
        end else begin
          want = snapshot_q.pop_front();
          check_field("accepted",        64'(want.accepted),      64'(got.accepted));
          check_field("mode_now",        64'(want.mode_now),      64'(got.mode_now));
          check_field("lease_state",     64'(want.lease_state),   64'(got.lease_state));
          check_field("is_configured",   64'(want.is_configured), 64'(got.is_configured));
          check_field("netmask_out",     64'(want.netmask_out),   64'(got.netmask_out));
          check_field("prefix_out",      64'(want.prefix_out),    64'(got.prefix_out));
          check_field("renew_deadline",  want.renew_deadline,     got.renew_deadline);
          check_field("rebind_deadline", want.rebind_deadline,    got.rebind_deadline);
          check_field("expiry_deadline", want.expiry_deadline,    got.expiry_deadline);
          check_field("retry_deadline",  want.retry_deadline,     got.retry_deadline);
          check_field("retry_delay",     64'(want.retry_delay),   64'(got.retry_delay));
        end
      end
      pending_o = snapshot_q.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: top-level bench of the DHCP lease timer
// Drives a directed sweep and then randomized lease sessions (acquire,
// apply lease, renew/rebind attempts and failures, with noise and manual
// settings mixed in) under several retry register settings, with random
// idle cycles on both channels. A separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  // Request codes the block does not define
  localparam logic [2:0]  REQ_RESERVED_LO = 3'd6;
  localparam logic [2:0]  REQ_RESERVED_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        calm = 1'b0;    // when set, neither side idles
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int          pending;
  int          fail_count;

  // Retry settings per phase; phase 0 runs on the reset values.
  logic [15:0] init_set [PHASES] = '{dlt_pkg::RETRY_INITIAL_RST, 16'd1, 16'd65535, 16'd0,
                                     16'd65535, 16'd0};
  logic [15:0] cap_set  [PHASES] = '{dlt_pkg::RETRY_CAP_RST, 16'd65535, 16'd1, 16'd4000,
                                     16'd65535, 16'd0};

  always #6 clk = ~clk;

  dlt_req_if req_ch ();
  dlt_res_if res_ch ();
  dlt_cfg_if cfg_ch ();

  dhcp_lease_timer_unit #(
    .MS_PER_SECOND(1000)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  dlt_lease_checker #(
    .MS_PER_SECOND(1000)
  ) lease_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_mon     (req_ch),
    .res_mon     (res_ch),
    .cfg_mon     (cfg_ch),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("dhcp_lease_timer_unit test failed");
      $finish;
    end
  end

  // Result side: hold ready low for a random stall, then take one transaction.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Fully random request: every field, every code, reserved ones included.
  function automatic dlt_pkg::req_t noise_req();
    dlt_pkg::req_t r;
    r.req_type        = 3'($urandom_range(0, 7));
    r.now_ms          = {$urandom, $urandom};
    r.host_address    = $urandom;
    r.offered_netmask = $urandom;
    r.manual_prefix   = 8'($urandom);
    r.gateway_address = $urandom;
    r.dns_address     = $urandom;
    r.lease_secs      = $urandom;
    r.renew_secs      = $urandom;
    r.rebind_secs     = $urandom;
    r.is_rebinding    = 1'($urandom);
    return r;
  endfunction

  // Fields the request kind ignores keep random content.
  function automatic dlt_pkg::req_t make_req(input logic [2:0] kind, input logic [63:0] now,
                                             input logic rebinding);
    dlt_pkg::req_t r;
    r = noise_req();
    r.req_type     = kind;
    r.now_ms       = now;
    r.is_rebinding = rebinding;
    return r;
  endfunction

  function automatic dlt_pkg::req_t make_lease(input logic [63:0] now,
                                               input logic [31:0] addr,
                                               input logic [31:0] mask,
                                               input logic [31:0] lease_s,
                                               input logic [31:0] t1,
                                               input logic [31:0] t2);
    dlt_pkg::req_t r;
    r = make_req(dlt_pkg::REQ_LEASE, now, 1'($urandom));
    r.host_address    = addr;
    r.offered_netmask = mask;
    r.lease_secs      = lease_s;
    r.renew_secs      = t1;
    r.rebind_secs     = t2;
    return r;
  endfunction

  function automatic dlt_pkg::req_t make_manual(input logic [31:0] addr,
                                                input logic [7:0] prefix,
                                                input logic [31:0] gw,
                                                input logic [31:0] dns);
    dlt_pkg::req_t r;
    r = noise_req();
    r.req_type        = dlt_pkg::REQ_MANUAL;
    r.host_address    = addr;
    r.manual_prefix   = prefix;
    r.gateway_address = gw;
    r.dns_address     = dns;
    return r;
  endfunction

  function automatic logic [31:0] prefix_mask(input int unsigned len);
    return (len == 0) ? 32'd0 : 32'hFFFF_FFFF << (32 - len);
  endfunction

  // Present one request after a random gap and hold it until taken. Valid
  // stays high on return so a back-to-back request needs no second write.
  task automatic send_request(input dlt_pkg::req_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every owed result is back, then idle.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dlt_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One lease lifetime: acquire, apply a lease with random terms, then a run
  // of renew/rebind attempts and failures at advancing times, with noise.
  task automatic run_session();
    logic [63:0] now;
    logic [63:0] quarter;
    logic [31:0] lease_s;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] step_max;
    logic        rb;
    int          ops;
    calm = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 9))
      0:       now = {$urandom, $urandom};
      1:       now = ~64'd0 - 64'($urandom);
      default: now = {24'd0, 8'($urandom_range(0, 255)), $urandom};
    endcase
    case ($urandom_range(0, 9))
      0:       send_request(make_req(dlt_pkg::REQ_CLEAR, now, 1'($urandom)));
      1:       ;
      default: send_request(make_req(dlt_pkg::REQ_BEGIN, now, 1'($urandom)));
    endcase
    case ($urandom_range(0, 9))
      0:       lease_s = $urandom_range(0, 3);
      1:       lease_s = $urandom;
      2:       lease_s = 32'hFFFF_FFFF;
      default: lease_s = $urandom_range(3, 2000);
    endcase
    case ($urandom_range(0, 4))
      0, 1:    t1 = 32'd0;
      2:       t1 = $urandom_range(0, lease_s);
      3:       t1 = $urandom;
      default: t1 = lease_s;
    endcase
    case ($urandom_range(0, 4))
      0, 1:    t2 = 32'd0;
      2:       t2 = $urandom_range(0, lease_s);
      3:       t2 = $urandom;
      default: t2 = lease_s;
    endcase
    addr = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
    mask = ($urandom_range(0, 6) == 0) ? $urandom : prefix_mask($urandom_range(0, 32));
    send_request(make_lease(now, addr, mask, lease_s, t1, t2));
    // Step time by up to a quarter of the lease so T1, T2 and expiry get crossed.
    quarter  = 64'(lease_s) * 64'd250;
    step_max = (quarter > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quarter[31:0];
    ops = $urandom_range(2, 10);
    for (int i = 0; i < ops; i++) begin
      now = now + 64'($urandom_range(0, step_max));
      rb  = (i >= ops / 2) ^ ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 19))
        0: send_request(noise_req());
        1: begin
          send_request(make_manual(
            ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom,
            ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 32)),
            ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom,
            ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom));
        end
        2, 3, 4, 5, 6, 7, 8, 9: send_request(make_req(dlt_pkg::REQ_ATTEMPT, now, rb));
        default: send_request(make_req(dlt_pkg::REQ_FAILURE, now, rb));
      endcase
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    init_set[PHASES-1] = 16'($urandom_range(1, 300));
    cap_set[PHASES-1]  = 16'($urandom_range(1, 5000));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sweep on the reset retry settings.
    send_request(make_req(dlt_pkg::REQ_CLEAR, 64'd0, 1'b0));
    send_request(make_req(dlt_pkg::REQ_BEGIN, 64'd0, 1'b0));
    send_request(make_req(REQ_RESERVED_LO, 64'd0, 1'b0));
    send_request(make_req(REQ_RESERVED_HI, 64'd0, 1'b1));
    // Attempt while acquiring: not configured yet
    send_request(make_req(dlt_pkg::REQ_ATTEMPT, 64'd100, 1'b0));
    // Lease rejects: zero address, holes in the mask, lease too short
    send_request(make_lease(64'd0, 32'd0, prefix_mask(24), 32'd3600, 32'd0, 32'd0));
    send_request(make_lease(64'd0, 32'h0A00_0001, 32'hFF00_FF00, 32'd3600, 32'd0, 32'd0));
    send_request(make_lease(64'd0, 32'h0A00_0001, prefix_mask(24), 32'd2, 32'd0, 32'd0));
    // Expiry overflows at the top of time; exactly reaching it is fine
    send_request(make_lease(~64'd0, 32'h0A00_0001, prefix_mask(24), 32'd3, 32'd0, 32'd0));
    send_request(make_lease(~64'd0 - 64'd3000, 32'h0A00_0001, prefix_mask(24), 32'd3,
                            32'd0, 32'd0));
    // Widest lease, all-ones address and mask
    send_request(make_lease(64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'd0, 32'd0));
    // T2 not above T1, then T2 past the lease
    send_request(make_lease(64'd1000, 32'h0A00_0001, prefix_mask(16), 32'd100,
                            32'd60, 32'd50));
    send_request(make_lease(64'd1000, 32'h0A00_0001, prefix_mask(8), 32'd100,
                            32'd40, 32'd150));
    // Short lease with an empty mask: expiry 25000, T1 15000, T2 22000
    send_request(make_lease(64'd5000, 32'hC0A8_0001, prefix_mask(0), 32'd20, 32'd0, 32'd0));
    send_request(make_req(dlt_pkg::REQ_FAILURE, 64'd6000, 1'b0));
    // Renew: delay doubles to the cap and the retry clamps to T2
    send_request(make_req(dlt_pkg::REQ_ATTEMPT, 64'd15000, 1'b0));
    send_request(make_req(dlt_pkg::REQ_FAILURE, 64'd16000, 1'b0));
    send_request(make_req(dlt_pkg::REQ_FAILURE, 64'd18000, 1'b0));
    send_request(make_req(dlt_pkg::REQ_FAILURE, 64'd21000, 1'b0));
    // Rebind near the top of time: retry saturates, then clamps to expiry
    send_request(make_req(dlt_pkg::REQ_ATTEMPT, ~64'd0 - 64'd10, 1'b1));
    send_request(make_req(dlt_pkg::REQ_FAILURE, ~64'd0, 1'b1));
    // Manual: prefix too long, zero gateway, zero DNS, then both extremes
    send_request(make_manual(32'h0A00_0002, 8'd33, 32'h0A00_0001, 32'h0808_0808));
    send_request(make_manual(32'h0A00_0002, 8'd24, 32'd0, 32'h0808_0808));
    send_request(make_manual(32'h0A00_0002, 8'd24, 32'h0A00_0001, 32'd0));
    send_request(make_manual(32'h0A00_0002, 8'd0, 32'h0A00_0001, 32'h0808_0808));
    send_request(make_manual(32'hFFFF_FFFF, 8'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(dlt_pkg::REQ_ATTEMPT, 64'd0, 1'b0));

    // Random sessions, one retry setting per phase; each change waits for
    // the block to drain.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        write_reg(dlt_pkg::CFG_RETRY_INITIAL, init_set[p]);
        write_reg(dlt_pkg::CFG_RETRY_CAP, cap_set[p]);
      end
      while (items_sent < (p + 1) * ITEMS_PER_PHASE) run_session();
    end

    settle();
    if (fail_count == 0) begin
      $display("dhcp_lease_timer_unit test passed");
    end else begin
      $display("dhcp_lease_timer_unit test failed");
    end
    $finish;
  end

endmodule
